// ===== src/tcc_pkg.sv =====
// Shared types, codes and constants of the text console cursor.
`timescale 1ns / 1ps
`default_nettype none

package tcc_pkg;

   // Field widths
   localparam int CODE_W  = 8;
   localparam int COLOR_W = 32;
   localparam int POS_W   = 8;

   // Packed stream widths, whole bytes
   localparam int REQ_DATA_W = 72;   // char_code, fore_color, back_color
   localparam int RSP_DATA_W = 88;   // cell_column, cell_row, glyph_code, draw_fore, draw_back

   // Character codes
   localparam logic [CODE_W-1:0] CODE_BACKSPACE = 8'd8;
   localparam logic [CODE_W-1:0] CODE_TAB       = 8'd9;
   localparam logic [CODE_W-1:0] CODE_NEWLINE   = 8'd10;
   localparam logic [CODE_W-1:0] CODE_SPACE     = 8'd32;

   // Sizing
   localparam int TAB_STOP_DEFAULT    = 8;
   localparam int MAX_WRITES          = 8;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Register reset values
   localparam logic [POS_W-1:0] COLUMNS_RESET = 8'd128;
   localparam logic [POS_W-1:0] ROWS_RESET    = 8'd48;

   // Register indexes on the configuration port
   typedef enum logic {
      REG_COLUMNS = 1'b0,
      REG_ROWS    = 1'b1
   } reg_index_type;

   // Classified operation
   typedef enum logic [1:0] {
      OP_PRINT,
      OP_NEWLINE,
      OP_BACKSPACE,
      OP_TAB
   } op_type;

   // One queued command
   typedef struct packed {
      op_type               op;
      logic [CODE_W-1:0]    glyph;
      logic [COLOR_W-1:0]   fore;
      logic [COLOR_W-1:0]   back;
   } entry_type;

   // Cursor position
   typedef struct packed {
      logic [POS_W-1:0] column;
      logic [POS_W-1:0] row;
   } pos_type;

   // Back engine states
   typedef enum logic {
      ST_IDLE,
      ST_TAB
   } back_state_type;

endpackage

`default_nettype wire

// ===== src/tcc_front.sv =====
// Front end: accepts character transactions and classifies them into commands.
`timescale 1ns / 1ps
`default_nettype none

module tcc_front
   import tcc_pkg::*;
(
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // char_code, fore_color, back_color
   output logic                       push,
   output entry_type                  push_entry,
   input  wire logic                  full
);

   logic [CODE_W-1:0] code;

   assign code       = req_tdata[CODE_W-1:0];
   assign req_tready = !full;
   assign push       = req_tvalid && !full;

   // Classify the character code
   always_comb begin
      push_entry.glyph = code;
      push_entry.fore  = req_tdata[CODE_W +: COLOR_W];
      push_entry.back  = req_tdata[CODE_W+COLOR_W +: COLOR_W];
      case (code)
         CODE_NEWLINE:   push_entry.op = OP_NEWLINE;
         CODE_BACKSPACE: push_entry.op = OP_BACKSPACE;
         CODE_TAB:       push_entry.op = OP_TAB;
         default:        push_entry.op = OP_PRINT;
      endcase
   end

endmodule

`default_nettype wire

// ===== src/tcc_queue.sv =====
// Short command queue between the front end and the back engine.
`timescale 1ns / 1ps
`default_nettype none

module tcc_queue
   import tcc_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   output logic           full,
   input  wire logic      pop,
   output entry_type      pop_entry,
   output logic           empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff,  count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== src/tcc_back.sv =====
// Back engine: keeps the cursor and turns commands into cell-write transactions.
`timescale 1ns / 1ps
`default_nettype none

module tcc_back
   import tcc_pkg::*;
#(
   parameter int TAB_STOP = TAB_STOP_DEFAULT
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [POS_W-1:0]      columns,     // already forced to at least 1
   input  wire logic [POS_W-1:0]      rows,        // already forced to at least 1
   input  wire logic                  empty,
   input  wire entry_type             entry,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // cell_column, cell_row, glyph_code,
                                                   // draw_fore, draw_back
   output logic                       rsp_tlast    // last_write
);

   localparam int PH_W  = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
   localparam int CNT_W = $clog2(MAX_WRITES + 1);

   back_state_type       state_ff, state_in;
   pos_type              cur_ff, cur_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;

   logic                 valid_ff, valid_in;
   logic [POS_W-1:0]     col_ff, col_in;
   logic [POS_W-1:0]     row_ff, row_in;
   logic [CODE_W-1:0]    glyph_ff, glyph_in;
   logic [COLOR_W-1:0]   fore_ff, fore_in;
   logic [COLOR_W-1:0]   back_ff, back_in;
   logic                 last_ff, last_in;

   pos_type              wpos, adv, bs;
   logic                 out_free;
   logic [PH_W-1:0]      phase_lut [256];
   logic [POS_W-1:0]     gap_to_stop;
   logic [CNT_W-1:0]     tab_count;

   // Column phase within a tab stop, built at elaboration
   for (genvar g = 0; g < 256; g++) begin : g_phase
      assign phase_lut[g] = PH_W'(g % TAB_STOP);
   end

   // Wrap rule: past the row end starts the next row, past the last row returns to row 0
   function automatic pos_type wrap_pos(pos_type p, logic [POS_W-1:0] cols,
                                        logic [POS_W-1:0] nrows);
      pos_type r;
      r = p;
      if (r.column >= cols) begin
         r.column = '0;
         r.row    = r.row + 1'b1;
      end
      if (r.row >= nrows) begin
         r.row = '0;
      end
      return r;
   endfunction

   always_comb begin
      wpos = wrap_pos(cur_ff, columns, rows);
      adv  = wrap_pos('{column: wpos.column + 1'b1, row: wpos.row}, columns, rows);
      // Step back one cell
      if (wpos.column == '0) begin
         bs.column = columns - 1'b1;
         bs.row    = (wpos.row == '0) ? rows - 1'b1 : wpos.row - 1'b1;
      end else begin
         bs.column = wpos.column - 1'b1;
         bs.row    = wpos.row;
      end
      // Spaces up to the next tab stop, capped
      gap_to_stop = POS_W'(TAB_STOP) - POS_W'(phase_lut[wpos.column]);
      tab_count   = (gap_to_stop > POS_W'(MAX_WRITES)) ? CNT_W'(MAX_WRITES)
                                                       : CNT_W'(gap_to_stop);
   end

   assign out_free = !valid_ff || rsp_tready;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      rem_in   = rem_ff;
      pop      = 1'b0;
      valid_in = out_free ? 1'b0 : valid_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      glyph_in = glyph_ff;
      fore_in  = fore_ff;
      back_in  = back_ff;
      last_in  = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (out_free && !empty) begin
               pop     = 1'b1;
               fore_in = entry.fore;
               back_in = entry.back;
               case (entry.op)
                  OP_NEWLINE: begin
                     cur_in = wrap_pos('{column: '0, row: wpos.row + 1'b1}, columns, rows);
                  end
                  OP_BACKSPACE: begin
                     valid_in = 1'b1;
                     col_in   = bs.column;
                     row_in   = bs.row;
                     glyph_in = CODE_SPACE;
                     last_in  = 1'b1;
                     cur_in   = bs;
                  end
                  OP_TAB: begin
                     valid_in = 1'b1;
                     col_in   = wpos.column;
                     row_in   = wpos.row;
                     glyph_in = CODE_SPACE;
                     cur_in   = adv;
                     if (tab_count > CNT_W'(1)) begin
                        last_in  = 1'b0;
                        rem_in   = tab_count - 1'b1;
                        state_in = ST_TAB;
                     end else begin
                        last_in  = 1'b1;
                     end
                  end
                  default: begin
                     valid_in = 1'b1;
                     col_in   = wpos.column;
                     row_in   = wpos.row;
                     glyph_in = entry.glyph;
                     last_in  = 1'b1;
                     cur_in   = adv;
                  end
               endcase
            end
         end
         ST_TAB: begin
            // Colors stay in the output register for the whole run
            if (out_free) begin
               valid_in = 1'b1;
               col_in   = wpos.column;
               row_in   = wpos.row;
               glyph_in = CODE_SPACE;
               cur_in   = adv;
               rem_in   = rem_ff - 1'b1;
               last_in  = (rem_ff == CNT_W'(1));
               if (rem_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cur_ff   <= '0;
         rem_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cur_ff   <= cur_in;
         rem_ff   <= rem_in;
         valid_ff <= valid_in;
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      col_ff   <= col_in;
      row_ff   <= row_in;
      glyph_ff <= glyph_in;
      fore_ff  <= fore_in;
      back_ff  <= back_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {back_ff, fore_ff, glyph_ff, row_ff, col_ff};
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

// ===== src/text_console_cursor.sv =====
// Top level of the text console cursor: configuration registers and block wiring.
`timescale 1ns / 1ps
`default_nettype none

// Turns a stream of character bytes into cell-write transactions for a text console.
// A printable byte or a backspace gives one cell write; a newline moves the cursor
// and gives no write; a tab gives 1 to 8 space writes, one per cycle while rsp is not
// stalled, up to the next tab stop. The back engine issues at most one
// cell write per cycle, so that is the rate; a stalled rsp side stops it while the
// command queue keeps taking input until it fills. rsp_tlast marks the final write
// of each character. There is no clearing pass after reset. Set columns and rows
// only while no transaction is in flight; a zero size counts as one.

module text_console_cursor
   import tcc_pkg::*;
#(
   parameter int TAB_STOP    = TAB_STOP_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // char_code, fore_color, back_color
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // cell_column, cell_row, glyph_code,
                                                   // draw_fore, draw_back
   output logic                       rsp_tlast,   // last_write
   input  wire logic                  csr_we,
   input  wire logic                  csr_index,
   input  wire logic [POS_W-1:0]      csr_wdata
);

   logic [POS_W-1:0] columns_ff, columns_in;
   logic [POS_W-1:0] rows_ff, rows_in;
   logic [POS_W-1:0] eff_columns, eff_rows;

   logic             push, full, pop, empty;
   entry_type        push_entry, pop_entry;

   // Configuration writes
   always_comb begin
      columns_in = columns_ff;
      rows_in    = rows_ff;
      if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_COLUMNS: columns_in = csr_wdata;
            REG_ROWS:    rows_in    = csr_wdata;
            default:     ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= COLUMNS_RESET;
         rows_ff    <= ROWS_RESET;
      end else begin
         columns_ff <= columns_in;
         rows_ff    <= rows_in;
      end
   end

   // Zero sizes act as one
   assign eff_columns = (columns_ff == '0) ? POS_W'(1) : columns_ff;
   assign eff_rows    = (rows_ff == '0) ? POS_W'(1) : rows_ff;

   tcc_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push       (push),
      .push_entry (push_entry),
      .full       (full)
   );

   tcc_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .empty      (empty)
   );

   tcc_back #(
      .TAB_STOP (TAB_STOP)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .columns    (eff_columns),
      .rows       (eff_rows),
      .empty      (empty),
      .entry      (pop_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== src/tcc_checker.sv =====
// Port-level checks on the text console cursor, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tcc_checker
   import tcc_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tlast
);

   // A stalled cell write holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled rsp transaction changed");

   // Nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // Only tab fills have a write after them, and those are spaces
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[23:16] == CODE_SPACE)
      else $error("non-final cell write is not a space");

   // A tab run goes on without a gap and with the same colors
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && rsp_tdata[87:24] == $past(rsp_tdata[87:24]))
      else $error("tab run broken or colors changed");

endmodule

bind text_console_cursor tcc_checker u_checker (.*);

`default_nettype wire
